// File: sv/segment_allocator_fit_compact_top_assert.svh
// Assertion macros for the segment allocator top level.
// Depends on clk and arst_n being visible where the macros are used.
`ifndef SEGMENT_ALLOCATOR_FIT_COMPACT_TOP_ASSERT_SVH
`define SEGMENT_ALLOCATOR_FIT_COMPACT_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SAC_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sac: implication check failed");

// Next-cycle implication, disabled during reset
`define SAC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sac: next-cycle check failed");

`endif

// File: sv/sac_pkg.sv
// Shared types and constants for the segment allocator.
// No dependencies; used by the controller, the datapath and the top level.
package sac_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int ADDR_BITS    = 24;
	localparam int LEN_W        = 25;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int END_W        = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;
	localparam int FRAG_W       = END_W + 2;
	localparam int SUM_W        = LEN_W + CNT_W;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [LEN_W-1:0] MEM_SIZE_RESET = LEN_W'(1 << 24);

	typedef enum logic [1:0] {
		CFG_FIT_MODE    = 2'd0,
		CFG_MEMORY_SIZE = 2'd1,
		CFG_FIXED_SIZE  = 2'd2,
		CFG_RESERVED    = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic                 func;
		logic [LEN_W-1:0]     request_length;
		logic [ADDR_BITS-1:0] release_base;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [ADDR_BITS-1:0] granted_base;
		logic                 compacted;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [LEN_W-1:0]     length;
	} entry_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_FIND_INIT,
		OP_NO_SPACE,
		OP_FULL,
		OP_NOT_FOUND,
		OP_EVAL,
		OP_EVAL_TAIL,
		OP_CMP_INIT,
		OP_CMP_WR,
		OP_INS_INIT,
		OP_INS_READ,
		OP_INS_SHIFT,
		OP_INS_PUT,
		OP_STEP,
		OP_REL_HIT,
		OP_SHD_WR,
		OP_SHRINK,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic idle;
	} cmd_t;

	typedef struct packed {
		logic is_release;
		logic no_space;
		logic full;
		logic cnt_zero;
		logic last;
		logic idx_zero;
		logic first_hit;
		logic have;
		logic compacted;
		logic ins_shift;
		logic rel_match;
		logic out_hold;
	} stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_FIND_RD,
		S_FIND_EV,
		S_TAIL,
		S_DECIDE,
		S_RETRY,
		S_CMP_RD,
		S_CMP_WR,
		S_INS_RD,
		S_INS_EV,
		S_REL_RD,
		S_REL_EV,
		S_SHD_RD,
		S_SHD_WR,
		S_SHRINK,
		S_DONE
	} state_t;

endpackage

// File: sv/sac_ctrl.sv
// Sequencer for the segment allocator: walks, compaction, insert and release.
// Depends on sac_pkg; drives the datapath through cmd_t and reads stat_t.
module sac_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  sac_pkg::stat_t stat,
	output sac_pkg::cmd_t  cmd
);

	sac_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sac_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath command
	always_comb begin
		state_d  = state_q;
		cmd.op   = sac_pkg::OP_NONE;
		cmd.idle = (state_q == sac_pkg::S_IDLE);
		unique case (state_q)
			sac_pkg::S_IDLE: begin
				if (req_valid) begin
					cmd.op  = sac_pkg::OP_ACCEPT;
					state_d = sac_pkg::S_CHECK;
				end
			end
			sac_pkg::S_CHECK: begin
				if (stat.is_release) begin
					if (stat.cnt_zero) begin
						cmd.op  = sac_pkg::OP_NOT_FOUND;
						state_d = sac_pkg::S_DONE;
					end else begin
						cmd.op  = sac_pkg::OP_FIND_INIT;
						state_d = sac_pkg::S_REL_RD;
					end
				end else if (stat.no_space) begin
					cmd.op  = sac_pkg::OP_NO_SPACE;
					state_d = sac_pkg::S_DONE;
				end else if (stat.full) begin
					cmd.op  = sac_pkg::OP_FULL;
					state_d = sac_pkg::S_DONE;
				end else begin
					cmd.op  = sac_pkg::OP_FIND_INIT;
					state_d = stat.cnt_zero ? sac_pkg::S_TAIL : sac_pkg::S_FIND_RD;
				end
			end
			sac_pkg::S_FIND_RD: begin
				state_d = sac_pkg::S_FIND_EV;
			end
			sac_pkg::S_FIND_EV: begin
				cmd.op = sac_pkg::OP_EVAL;
				if (stat.first_hit) begin
					state_d = sac_pkg::S_DECIDE;
				end else if (stat.last) begin
					state_d = sac_pkg::S_TAIL;
				end else begin
					state_d = sac_pkg::S_FIND_RD;
				end
			end
			sac_pkg::S_TAIL: begin
				cmd.op  = sac_pkg::OP_EVAL_TAIL;
				state_d = sac_pkg::S_DECIDE;
			end
			sac_pkg::S_DECIDE: begin
				if (stat.have) begin
					cmd.op  = sac_pkg::OP_INS_INIT;
					state_d = sac_pkg::S_INS_RD;
				end else if (stat.compacted) begin
					cmd.op  = sac_pkg::OP_NO_SPACE;
					state_d = sac_pkg::S_DONE;
				end else begin
					cmd.op  = sac_pkg::OP_CMP_INIT;
					state_d = stat.cnt_zero ? sac_pkg::S_RETRY : sac_pkg::S_CMP_RD;
				end
			end
			sac_pkg::S_RETRY: begin
				cmd.op  = sac_pkg::OP_FIND_INIT;
				state_d = stat.cnt_zero ? sac_pkg::S_TAIL : sac_pkg::S_FIND_RD;
			end
			sac_pkg::S_CMP_RD: begin
				state_d = sac_pkg::S_CMP_WR;
			end
			sac_pkg::S_CMP_WR: begin
				cmd.op  = sac_pkg::OP_CMP_WR;
				state_d = stat.last ? sac_pkg::S_RETRY : sac_pkg::S_CMP_RD;
			end
			sac_pkg::S_INS_RD: begin
				if (stat.idx_zero) begin
					cmd.op  = sac_pkg::OP_INS_PUT;
					state_d = sac_pkg::S_DONE;
				end else begin
					cmd.op  = sac_pkg::OP_INS_READ;
					state_d = sac_pkg::S_INS_EV;
				end
			end
			sac_pkg::S_INS_EV: begin
				if (stat.ins_shift) begin
					cmd.op  = sac_pkg::OP_INS_SHIFT;
					state_d = sac_pkg::S_INS_RD;
				end else begin
					cmd.op  = sac_pkg::OP_INS_PUT;
					state_d = sac_pkg::S_DONE;
				end
			end
			sac_pkg::S_REL_RD: begin
				state_d = sac_pkg::S_REL_EV;
			end
			sac_pkg::S_REL_EV: begin
				if (stat.rel_match) begin
					cmd.op  = sac_pkg::OP_REL_HIT;
					state_d = stat.last ? sac_pkg::S_SHRINK : sac_pkg::S_SHD_RD;
				end else if (stat.last) begin
					cmd.op  = sac_pkg::OP_NOT_FOUND;
					state_d = sac_pkg::S_DONE;
				end else begin
					cmd.op  = sac_pkg::OP_STEP;
					state_d = sac_pkg::S_REL_RD;
				end
			end
			sac_pkg::S_SHD_RD: begin
				state_d = sac_pkg::S_SHD_WR;
			end
			sac_pkg::S_SHD_WR: begin
				cmd.op  = sac_pkg::OP_SHD_WR;
				state_d = stat.last ? sac_pkg::S_SHRINK : sac_pkg::S_SHD_RD;
			end
			sac_pkg::S_SHRINK: begin
				cmd.op  = sac_pkg::OP_SHRINK;
				state_d = sac_pkg::S_DONE;
			end
			sac_pkg::S_DONE: begin
				if (!stat.out_hold) begin
					cmd.op  = sac_pkg::OP_EMIT;
					state_d = sac_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sac_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: sv/sac_dp.sv
// Datapath for the segment allocator: segment table memory, gap evaluation,
// compaction, configuration registers and the result register. Uses sac_pkg.
module sac_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sac_pkg::cmd_t            cmd,
	input  sac_pkg::req_t            req,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [sac_pkg::LEN_W-1:0] cfg_data,
	input  logic                     rsp_stall,
	output sac_pkg::stat_t           stat,
	output logic                     rsp_valid,
	output sac_pkg::rsp_t            rsp
);

	localparam int AW = sac_pkg::ADDR_BITS;
	localparam int LW = sac_pkg::LEN_W;
	localparam int IW = sac_pkg::IDX_W;
	localparam int CW = sac_pkg::CNT_W;
	localparam int EW = sac_pkg::END_W;
	localparam int FW = sac_pkg::FRAG_W;
	localparam int SW = sac_pkg::SUM_W;

	sac_pkg::entry_t mem [sac_pkg::MAX_SEGMENTS];
	sac_pkg::entry_t rd_q;

	logic [1:0]      fit_mode_q;
	logic [LW-1:0]   mem_size_q;
	logic [LW-1:0]   fixed_q;
	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   tbl_sum_q;
	logic [CW-1:0]   idx_q;
	logic [EW-1:0]   prev_end_q;
	logic            have_q;
	logic [FW-1:0]   best_q;
	logic [AW-1:0]   chosen_q;
	logic            compacted_q;
	sac_pkg::status_t code_q;
	sac_pkg::req_t   req_q;
	logic            rsp_valid_q;
	sac_pkg::rsp_t   rsp_q;

	logic [CW-1:0]   idx_dec;
	logic [IW-1:0]   raddr;
	logic            we;
	logic [IW-1:0]   waddr;
	sac_pkg::entry_t wdata;
	logic            start_ok;
	logic [FW-1:0]   frag_base;
	logic [FW-1:0]   frag_tail;
	logic [FW-1:0]   frag;
	logic            fits_base;
	logic            fits;
	logic            better;
	logic            take;
	logic            mode_first;
	logic [AW-1:0]   cmp_base;
	logic [SW:0]     space_used;

	assign idx_dec  = idx_q - CW'(1);
	assign raddr    = (cmd.op == sac_pkg::OP_INS_READ) ? idx_dec[IW-1:0] : idx_q[IW-1:0];
	assign start_ok = (prev_end_q[EW-1:AW] == '0);

	// Gap size minus request, against the next entry and against the tail
	assign frag_base = FW'(rd_q.base) - FW'(prev_end_q) - FW'(req_q.request_length);
	assign frag_tail = FW'(mem_size_q) - FW'(prev_end_q) - FW'(req_q.request_length);
	assign frag      = (cmd.op == sac_pkg::OP_EVAL_TAIL) ? frag_tail : frag_base;
	assign fits_base = !frag_base[FW-1] && start_ok;
	assign fits      = !frag[FW-1] && start_ok;

	assign mode_first = (fit_mode_q != sac_pkg::FIT_BEST) && (fit_mode_q != sac_pkg::FIT_WORST);

	// Pick the fit rule; ties in best and worst fit favor the later gap
	always_comb begin
		case (fit_mode_q)
			sac_pkg::FIT_BEST:  better = (frag <= best_q);
			sac_pkg::FIT_WORST: better = (frag >= best_q);
			default:            better = 1'b0;
		endcase
	end
	assign take = fits && (!have_q || better);

	// Slide down, clamped to the highest representable base
	assign cmp_base = start_ok ? prev_end_q[AW-1:0] : '1;

	assign space_used = (SW + 1)'(fixed_q) + (SW + 1)'(tbl_sum_q);

	// Table write port
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = rd_q;
		case (cmd.op)
			sac_pkg::OP_CMP_WR: begin
				we    = 1'b1;
				wdata = '{base: cmp_base, length: rd_q.length};
			end
			sac_pkg::OP_INS_SHIFT: begin
				we = 1'b1;
			end
			sac_pkg::OP_INS_PUT: begin
				we    = 1'b1;
				wdata = '{base: chosen_q, length: req_q.request_length};
			end
			sac_pkg::OP_SHD_WR: begin
				we    = 1'b1;
				waddr = idx_dec[IW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Segment table with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= sac_pkg::FIT_FIRST;
			mem_size_q <= sac_pkg::MEM_SIZE_RESET;
			fixed_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sac_pkg::CFG_FIT_MODE:    fit_mode_q <= cfg_data[1:0];
				sac_pkg::CFG_MEMORY_SIZE: mem_size_q <= cfg_data;
				sac_pkg::CFG_FIXED_SIZE:  fixed_q    <= cfg_data;
				default:                  fit_mode_q <= fit_mode_q;
			endcase
		end
	end

	// Walk state, table bookkeeping and request word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			tbl_sum_q   <= '0;
			idx_q       <= '0;
			prev_end_q  <= '0;
			have_q      <= 1'b0;
			best_q      <= '0;
			chosen_q    <= '0;
			compacted_q <= 1'b0;
			code_q      <= sac_pkg::ST_DONE;
			req_q       <= '0;
		end else begin
			case (cmd.op)
				sac_pkg::OP_ACCEPT: begin
					req_q       <= req;
					compacted_q <= 1'b0;
					code_q      <= sac_pkg::ST_DONE;
				end
				sac_pkg::OP_FIND_INIT: begin
					idx_q      <= '0;
					prev_end_q <= EW'(fixed_q);
					have_q     <= 1'b0;
				end
				sac_pkg::OP_NO_SPACE:  code_q <= sac_pkg::ST_NO_SPACE;
				sac_pkg::OP_FULL:      code_q <= sac_pkg::ST_FULL;
				sac_pkg::OP_NOT_FOUND: code_q <= sac_pkg::ST_NOT_FOUND;
				sac_pkg::OP_EVAL, sac_pkg::OP_EVAL_TAIL: begin
					if (take) begin
						have_q   <= 1'b1;
						best_q   <= frag;
						chosen_q <= prev_end_q[AW-1:0];
					end
					if (cmd.op == sac_pkg::OP_EVAL) begin
						prev_end_q <= EW'(rd_q.base) + EW'(rd_q.length);
						idx_q      <= idx_q + CW'(1);
					end
				end
				sac_pkg::OP_CMP_INIT: begin
					idx_q       <= '0;
					prev_end_q  <= EW'(fixed_q);
					compacted_q <= 1'b1;
				end
				sac_pkg::OP_CMP_WR: begin
					prev_end_q <= EW'(cmp_base) + EW'(rd_q.length);
					idx_q      <= idx_q + CW'(1);
				end
				sac_pkg::OP_INS_INIT:  idx_q <= cnt_q;
				sac_pkg::OP_INS_SHIFT: idx_q <= idx_dec;
				sac_pkg::OP_INS_PUT: begin
					cnt_q     <= cnt_q + CW'(1);
					tbl_sum_q <= tbl_sum_q + SW'(req_q.request_length);
				end
				sac_pkg::OP_STEP: idx_q <= idx_q + CW'(1);
				sac_pkg::OP_REL_HIT: begin
					tbl_sum_q <= tbl_sum_q - SW'(req_q.request_length);
					idx_q     <= idx_q + CW'(1);
				end
				sac_pkg::OP_SHD_WR: idx_q <= idx_q + CW'(1);
				sac_pkg::OP_SHRINK: cnt_q <= cnt_q - CW'(1);
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// Result register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.op == sac_pkg::OP_EMIT) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == sac_pkg::OP_EMIT) begin
			rsp_q.status       <= code_q;
			rsp_q.granted_base <= ((code_q == sac_pkg::ST_DONE) &&
				(req_q.func == sac_pkg::FUNC_ALLOC)) ? chosen_q : '0;
			rsp_q.compacted    <= compacted_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status back to the sequencer
	assign stat.is_release = (req_q.func == sac_pkg::FUNC_RELEASE);
	assign stat.no_space   = ((SW + 1)'(mem_size_q) <= space_used);
	assign stat.full       = (cnt_q == CW'(sac_pkg::MAX_SEGMENTS));
	assign stat.cnt_zero   = (cnt_q == '0);
	assign stat.last       = ((idx_q + CW'(1)) == cnt_q);
	assign stat.idx_zero   = (idx_q == '0);
	assign stat.first_hit  = mode_first && fits_base;
	assign stat.have       = have_q;
	assign stat.compacted  = compacted_q;
	assign stat.ins_shift  = (rd_q.base > chosen_q);
	assign stat.rel_match  = (rd_q.base == req_q.release_base) &&
		(rd_q.length == req_q.request_length);
	assign stat.out_hold   = rsp_valid_q && rsp_stall;

endmodule

// File: sv/segment_allocator_fit_compact_top.sv
// Segment allocator with first, best or worst fit and one-shot compaction.
// Request channel: req_valid/req_stall carrying req (func, request_length,
// release_base); a word is taken when req_valid is high and req_stall low.
// Response channel: rsp_valid/rsp_stall carrying rsp (status, granted_base,
// compacted); exactly one response word per request word.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 fit mode, 1 memory
// size, 2 fixed segment size) and cfg_data; writes are taken only while idle.
// Operation: one request at a time. Every table access goes through the
// table memory as a read step and then an evaluate or write step per entry.
// An allocate walks the table, may compact it once and retry, then shifts
// entries up to insert; a release searches, shifts the rest down and shrinks.
// The response sits in an output register, so a new request is taken while an
// earlier response is still stalled; a finished request waits for that
// register to drain. Reset empties the table, restores the default registers
// and clears any pending response; the table memory itself is not cleared.
// Depends on sac_pkg, sac_ctrl, sac_dp and the assertion macro header.
module segment_allocator_fit_compact_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  sac_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output sac_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [sac_pkg::LEN_W-1:0] cfg_data
);

	sac_pkg::cmd_t  cmd;
	sac_pkg::stat_t stat;

	// Sequencer
	sac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Table, evaluation and result register
	sac_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// Take words and configuration only between requests
	assign req_stall = !cmd.idle;
	assign cfg_ready = cmd.idle;

`include "segment_allocator_fit_compact_top_assert.svh"

	// An accepted word makes the block busy
	`SAC_ASSERT_NEXT(a_take_busy, req_valid && !req_stall, req_stall)
	// A fresh response only follows request work
	`SAC_ASSERT_IMPLY(a_rsp_after_work, $rose(rsp_valid), $past(req_stall))
	// The sequencer never emits while the result register is held
	`SAC_ASSERT_IMPLY(a_emit_free, cmd.op == sac_pkg::OP_EMIT, !(rsp_valid && rsp_stall))

endmodule
